// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/sfr_pkg.sv =====
package sfr_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int DATA_BYTES   = 22;
    localparam int BYTE_W       = 8;
    localparam int CHAN_BITS    = 11;
    localparam int NUM_CHANNELS = 16;
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int CHAN_IDX_W   = $clog2(NUM_CHANNELS);
    localparam int BITS_W       = DATA_BYTES * BYTE_W;
    localparam int CFG_IDX_W    = 1;
    localparam int OUT_TDATA_W  = ((CHAN_IDX_W + CHAN_BITS + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h0F;
    localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_COLLECT = 3'b010,
        ST_EMIT    = 3'b100
    } t_state;

    typedef struct packed {
        logic shift_byte;
        logic shift_chan;
    } t_dp_cmd;

    typedef struct packed {
        logic hdr_match;
        logic ftr_match;
    } t_dp_sts;

endpackage

// ===== sv/sfr_datapath.sv =====
module sfr_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sfr_pkg::BYTE_W-1:0]          i_cfg_wdata,
    input  logic [sfr_pkg::BYTE_W-1:0]          i_byte,
    input  sfr_pkg::t_dp_cmd                    i_cmd,
    output sfr_pkg::t_dp_sts                    o_sts,
    output logic [sfr_pkg::CHAN_BITS-1:0]       o_chan_value
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] r_header;
    logic [BYTE_W-1:0] r_footer;
    logic [BITS_W-1:0] r_bits;
    logic [BITS_W-1:0] n_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_footer <= FOOTER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HEADER: r_header <= i_cfg_wdata;
                REG_FOOTER: r_footer <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // data bytes enter at the top, channels leave at the bottom
    always_comb begin
        n_bits = r_bits;
        if (i_cmd.shift_byte) begin
            n_bits = {i_byte, r_bits[BITS_W-1:BYTE_W]};
        end else if (i_cmd.shift_chan) begin
            n_bits = {CHAN_BITS'(0), r_bits[BITS_W-1:CHAN_BITS]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

    assign o_sts.hdr_match = (i_byte == r_header);
    assign o_sts.ftr_match = (i_byte == r_footer);
    assign o_chan_value    = r_bits[CHAN_BITS-1:0];

endmodule

// ===== sv/sfr_ctrl.sv =====
module sfr_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sfr_pkg::CHAN_IDX_W-1:0]      o_chan_index,
    output logic                                o_last,
    input  sfr_pkg::t_dp_sts                    i_sts,
    output sfr_pkg::t_dp_cmd                    o_cmd
);
    import sfr_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      n_pos;
    logic [CHAN_IDX_W-1:0] r_chan;
    logic [CHAN_IDX_W-1:0] n_chan;
    logic                  in_acc;
    logic                  out_acc;

    assign o_in_ready   = (r_state == ST_IDLE) || (r_state == ST_COLLECT);
    assign o_out_valid  = (r_state == ST_EMIT);
    assign o_chan_index = r_chan;
    assign o_last       = (r_chan == CHAN_IDX_W'(NUM_CHANNELS - 1));
    assign in_acc       = i_in_valid && o_in_ready;
    assign out_acc      = o_out_valid && i_out_ready;

    always_comb begin
        n_state          = r_state;
        n_pos            = r_pos;
        n_chan           = r_chan;
        o_cmd.shift_byte = 1'b0;
        o_cmd.shift_chan = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_sts.hdr_match) begin
                    n_state = ST_COLLECT;
                    n_pos   = POS_W'(1);
                end
            end
            ST_COLLECT: begin
                if (in_acc) begin
                    o_cmd.shift_byte = (r_pos inside {[POS_W'(1):POS_W'(DATA_BYTES)]});
                    if (r_pos == POS_W'(FRAME_BYTES - 1)) begin
                        n_pos   = '0;
                        n_chan  = '0;
                        n_state = i_sts.ftr_match ? ST_EMIT : ST_IDLE;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    o_cmd.shift_chan = 1'b1;
                    n_chan           = r_chan + CHAN_IDX_W'(1);
                    if (o_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_chan  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_chan  <= n_chan;
        end
    end

endmodule

// ===== sv/sbus_frame_receiver_unit.sv =====
// S.BUS frame receiver for 16 proportional channels. Received bytes come in on the s_axis side,
// one transaction per byte. Bytes are dropped until one equals the header register; the next
// 24 bytes complete the frame. If the final byte equals the footer register, the block sends
// 16 transactions on the m_axis side, channel 0 to 15, each holding the channel number and its
// 11-bit value unpacked LSB-first from data bytes 1 to 22; tlast marks channel 15. A bad footer
// drops the frame without output. A header value inside a frame is ordinary data. Input bytes
// are taken one per cycle while idle or collecting. After a good frame, input stalls for the
// 16 output transactions, one per cycle while m_axis_tready is high, since the channels are
// shifted out of one 176-bit data register 11 bits at a time. The flags byte is not decoded.
// Configuration writes must happen while no frame is in progress.
module sbus_frame_receiver_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sfr_pkg::BYTE_W-1:0]          i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]          s_axis_tdata,  // data_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sfr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // channel_index, channel_value, pad
    output logic                                m_axis_tlast   // last_channel
);
    import sfr_pkg::*;

    t_dp_cmd               dp_cmd;
    t_dp_sts               dp_sts;
    logic [CHAN_BITS-1:0]  chan_value;
    logic [CHAN_IDX_W-1:0] chan_index;

    sfr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_chan_index (chan_index),
        .o_last       (m_axis_tlast),
        .i_sts        (dp_sts),
        .o_cmd        (dp_cmd)
    );

    sfr_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_byte       (s_axis_tdata),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .o_chan_value (chan_value)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - CHAN_BITS - CHAN_IDX_W)'(0), chan_value, chan_index};

endmodule

// ===== sv/sfr_checker.sv =====
`include "assert_macros.svh"

module sfr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [sfr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                m_axis_tlast
);
    import sfr_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    `ASSERT_IMPL(a_no_input_while_sending, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)

    `ASSERT_IMPL(a_last_on_final_chan, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tlast == (m_axis_tdata[CHAN_IDX_W-1:0] == CHAN_IDX_W'(NUM_CHANNELS - 1)))

    `ASSERT_NEXT(a_chan_sequence, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
        m_axis_tvalid &&
        (m_axis_tdata[CHAN_IDX_W-1:0] == $past(m_axis_tdata[CHAN_IDX_W-1:0]) + CHAN_IDX_W'(1)))

    `ASSERT_NEXT(a_frame_ends, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast,
        !m_axis_tvalid && s_axis_tready)

endmodule

bind sbus_frame_receiver_unit sfr_checker u_sfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
